@@ src/scd_pkg.sv @@
// Shared types, codes and constants of the serial command deframer.
package scd_pkg;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_TEXT_SHORT = 3'd1,
    ST_TEXT_LONG  = 3'd2,
    ST_SIZE_LARGE = 3'd3,
    ST_BAD_FOOTER = 3'd4
  } status_e;

  localparam logic KIND_TEXT = 1'b0;
  localparam logic KIND_BIN  = 1'b1;

  localparam logic [7:0]  SYNC_BYTE0  = 8'hAB;
  localparam logic [7:0]  SYNC_BYTE1  = 8'hCD;
  localparam logic [7:0]  FOOT_BYTE0  = 8'hDC;
  localparam logic [7:0]  FOOT_BYTE1  = 8'hBA;
  localparam logic [7:0]  TEXT_TERM   = 8'h3B;
  localparam logic [7:0]  CHAR_FIRST  = 8'h41;
  localparam logic [7:0]  CHAR_LAST   = 8'h5A;
  localparam logic [15:0] ID_OBF_OFF  = 16'h0514;
  localparam logic [15:0] ID_OBF_ON   = 16'h6902;
  localparam int unsigned BodyOverhead = 8;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic [7:0] index;
    logic       last;
    status_e    status;
  } item_t;

  // One request from the parser: one item, or two when pair is set.
  typedef struct packed {
    item_t it0;
    item_t it1;
    logic  pair;
  } cmd_t;

  function automatic logic [7:0] obf_key(input logic [3:0] pos);
    logic [7:0] k;
    case (pos)
      4'd0:    k = 8'h16;
      4'd1:    k = 8'h6C;
      4'd2:    k = 8'h14;
      4'd3:    k = 8'hE6;
      4'd4:    k = 8'h2E;
      4'd5:    k = 8'h91;
      4'd6:    k = 8'h0D;
      4'd7:    k = 8'h40;
      4'd8:    k = 8'h21;
      4'd9:    k = 8'h35;
      4'd10:   k = 8'hD5;
      4'd11:   k = 8'h40;
      4'd12:   k = 8'h13;
      4'd13:   k = 8'h03;
      4'd14:   k = 8'hE9;
      default: k = 8'h80;
    endcase
    return k;
  endfunction

endpackage

@@ src/scd_parser.sv @@
// Front end: frame parser that turns received bytes into emit requests.
module scd_parser import scd_pkg::*; #(
  parameter int unsigned BUFFER_BYTES   = 256,
  parameter int unsigned TEXT_MAX_CHARS = 14
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  input  logic       q_room_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  localparam int unsigned SizeMax = BUFFER_BYTES - BodyOverhead;
  localparam int unsigned CntW    = $clog2(SizeMax + 3);
  localparam int unsigned TlW     = $clog2(TEXT_MAX_CHARS + 1);

  typedef enum logic [2:0] {
    M_IDLE, M_TEXT, M_SYNC, M_SIZE_LO, M_SIZE_HI, M_BODY, M_FOOT1, M_FOOT2
  } mode_e;

  mode_e           mode_q, mode_d;
  logic            obf_q, obf_d;
  logic [CntW-1:0] size_q, size_d;
  logic [7:0]      size_lo_q, size_lo_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]      held_q, held_d;
  logic [TlW-1:0]  tlen_q, tlen_d;
  logic            push_q, push_d;
  cmd_t            cmd_q, cmd_d;

  logic            accept;
  logic [TlW-1:0]  tlen_inc;
  logic [CntW-1:0] cnt_inc;
  logic [15:0]     size_word;
  logic [15:0]     body_id;
  logic            obf_new;
  logic [7:0]      key_cur;

  assign in_ready_o = q_room_i;
  assign accept     = in_valid_i && q_room_i;
  assign tlen_inc   = tlen_q + TlW'(1);
  assign cnt_inc    = cnt_q + CntW'(1);
  assign size_word  = {rx_byte_i, size_lo_q};
  assign body_id    = {rx_byte_i, held_q};
  assign key_cur    = obf_q ? obf_key(cnt_q[3:0]) : 8'h00;

  always_comb begin
    obf_new = obf_q;
    if (body_id == ID_OBF_OFF) begin
      obf_new = 1'b0;
    end
    if (body_id == ID_OBF_ON) begin
      obf_new = 1'b1;
    end
  end

  always_comb begin
    mode_d    = mode_q;
    obf_d     = obf_q;
    size_d    = size_q;
    size_lo_d = size_lo_q;
    cnt_d     = cnt_q;
    held_d    = held_q;
    tlen_d    = tlen_q;
    push_d    = 1'b0;
    cmd_d     = '0;
    if (accept) begin
      unique case (mode_q)
        M_IDLE: begin
          if (rx_byte_i >= CHAR_FIRST && rx_byte_i <= CHAR_LAST) begin
            push_d          = 1'b1;
            cmd_d.it0.kind  = KIND_TEXT;
            cmd_d.it0.data  = rx_byte_i;
            tlen_d          = TlW'(1);
            mode_d          = M_TEXT;
          end else if (rx_byte_i == SYNC_BYTE0) begin
            mode_d = M_SYNC;
          end
        end
        M_TEXT: begin
          push_d         = 1'b1;
          cmd_d.it0.kind = KIND_TEXT;
          if (rx_byte_i == TEXT_TERM) begin
            cmd_d.it0.index  = 8'(tlen_q);
            cmd_d.it0.last   = 1'b1;
            cmd_d.it0.status = (tlen_q >= TlW'(2)) ? ST_OK : ST_TEXT_SHORT;
            mode_d           = M_IDLE;
          end else begin
            cmd_d.it0.data  = rx_byte_i;
            cmd_d.it0.index = 8'(tlen_q);
            tlen_d          = tlen_inc;
            if (tlen_inc >= TlW'(TEXT_MAX_CHARS)) begin
              cmd_d.pair       = 1'b1;
              cmd_d.it1.kind   = KIND_TEXT;
              cmd_d.it1.index  = 8'(tlen_inc);
              cmd_d.it1.last   = 1'b1;
              cmd_d.it1.status = ST_TEXT_LONG;
              mode_d           = M_IDLE;
            end
          end
        end
        M_SYNC: begin
          if (rx_byte_i == SYNC_BYTE1) begin
            mode_d = M_SIZE_LO;
          end else if (rx_byte_i != SYNC_BYTE0) begin
            mode_d = M_IDLE;
          end
        end
        M_SIZE_LO: begin
          size_lo_d = rx_byte_i;
          mode_d    = M_SIZE_HI;
        end
        M_SIZE_HI: begin
          if (size_word > 16'(SizeMax)) begin
            push_d           = 1'b1;
            cmd_d.it0.kind   = KIND_BIN;
            cmd_d.it0.last   = 1'b1;
            cmd_d.it0.status = ST_SIZE_LARGE;
            mode_d           = M_IDLE;
          end else begin
            size_d = size_word[CntW-1:0];
            cnt_d  = '0;
            mode_d = M_BODY;
          end
        end
        M_BODY: begin
          if (cnt_q == '0) begin
            held_d = rx_byte_i;
          end else if (cnt_q == CntW'(1)) begin
            obf_d           = obf_new;
            push_d          = 1'b1;
            cmd_d.pair      = 1'b1;
            cmd_d.it0.kind  = KIND_BIN;
            cmd_d.it0.data  = held_q ^ (obf_new ? obf_key(4'd0) : 8'h00);
            cmd_d.it1.kind  = KIND_BIN;
            cmd_d.it1.data  = rx_byte_i ^ (obf_new ? obf_key(4'd1) : 8'h00);
            cmd_d.it1.index = 8'd1;
          end else begin
            push_d          = 1'b1;
            cmd_d.it0.kind  = KIND_BIN;
            cmd_d.it0.data  = rx_byte_i ^ key_cur;
            cmd_d.it0.index = 8'(cnt_q);
          end
          cnt_d = cnt_inc;
          if ({1'b0, cnt_inc} >= {1'b0, size_q} + (CntW + 1)'(2)) begin
            mode_d = M_FOOT1;
          end
        end
        M_FOOT1: begin
          if (rx_byte_i == FOOT_BYTE0) begin
            mode_d = M_FOOT2;
          end else begin
            push_d           = 1'b1;
            cmd_d.it0.kind   = KIND_BIN;
            cmd_d.it0.index  = 8'(cnt_q);
            cmd_d.it0.last   = 1'b1;
            cmd_d.it0.status = ST_BAD_FOOTER;
            mode_d           = M_IDLE;
          end
        end
        M_FOOT2: begin
          push_d           = 1'b1;
          cmd_d.it0.kind   = KIND_BIN;
          cmd_d.it0.index  = 8'(cnt_q);
          cmd_d.it0.last   = 1'b1;
          cmd_d.it0.status = (rx_byte_i == FOOT_BYTE1) ? ST_OK : ST_BAD_FOOTER;
          mode_d           = M_IDLE;
        end
        default: begin
          mode_d = M_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= M_IDLE;
      obf_q     <= 1'b1;
      size_q    <= '0;
      size_lo_q <= '0;
      cnt_q     <= '0;
      held_q    <= '0;
      tlen_q    <= '0;
      push_q    <= 1'b0;
      cmd_q     <= '0;
    end else begin
      mode_q    <= mode_d;
      obf_q     <= obf_d;
      size_q    <= size_d;
      size_lo_q <= size_lo_d;
      cnt_q     <= cnt_d;
      held_q    <= held_d;
      tlen_q    <= tlen_d;
      push_q    <= push_d;
      cmd_q     <= cmd_d;
    end
  end

  assign push_o = push_q;
  assign cmd_o  = cmd_q;

endmodule

@@ src/scd_queue.sv @@
// Request queue between the parser and the emitter.
module scd_queue import scd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t head_o,
  output logic room_o
);

  cmd_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] count_q;
  logic             do_pop;

  assign valid_o = (count_q != '0);
  assign do_pop  = pop_i && valid_o;
  // space for one request in flight plus the one being accepted
  assign room_o  = (count_q < QCntW'(QDepth - 1));

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  assign head_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      count_q <= count_q + QCntW'(push_i) - QCntW'(do_pop);
    end
  end

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCntW'(QDepth))
    else $error("queue level beyond depth");

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q < QCntW'(QDepth)) || pop_i)
    else $error("request written into full queue");

  a_push_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !do_pop |=> count_q == $past(count_q) + QCntW'(1))
    else $error("queue level did not follow write");

endmodule

@@ src/scd_emitter.sv @@
// Back end: expands queued requests into result items behind an output register.
module scd_emitter import scd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  q_valid_i,
  input  cmd_t  q_cmd_i,
  output logic  pop_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output item_t out_item_o
);

  logic  out_valid_q;
  item_t out_item_q;
  logic  sec_valid_q;
  item_t sec_item_q;
  logic  free;

  assign free  = !out_valid_q || out_ready_i;
  assign pop_o = free && !sec_valid_q && q_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sec_valid_q <= 1'b0;
    end else if (free) begin
      if (sec_valid_q) begin
        out_valid_q <= 1'b1;
        sec_valid_q <= 1'b0;
      end else begin
        out_valid_q <= q_valid_i;
        sec_valid_q <= q_valid_i && q_cmd_i.pair;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (free) begin
      if (sec_valid_q) begin
        out_item_q <= sec_item_q;
      end else if (q_valid_i) begin
        out_item_q <= q_cmd_i.it0;
        sec_item_q <= q_cmd_i.it1;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_sec_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sec_valid_q |-> out_valid_q)
    else $error("second item pending without a first");

  a_pop_when_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> free && !sec_valid_q)
    else $error("request taken while output busy");

  a_pair_holds_sec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && q_cmd_i.pair |=> sec_valid_q && out_valid_q)
    else $error("second item of a pair lost");

endmodule

@@ src/serial_command_deframer.sv @@
// Serial command deframer top level: stream ports around parser, queue and emitter.
//
// Input channel s_axis: one received byte per request on tdata[7:0].
// Output channel m_axis: one result item per request. tdata carries the
// character or deobfuscated body byte, the position in the frame and the
// status code; tuser carries the frame kind (0 text, 1 binary); tlast marks
// the closing item of a frame.
// Throughput: one byte per cycle in while the queue has room, one item per
// cycle out while the receiver is ready. A byte that yields two items (second
// body byte, overlong text) holds the emitter for its second item, absorbed by the request queue.
// An accepted byte reaches the output through the parser register, a queue
// entry, then the output register.
// Reset puts the parser in idle with obfuscation on and empties the queue
// and the output register.
// When the receiver stalls, the output register holds its item, the queue
// fills, and s_axis_tready_o drops once fewer than two queue entries are free.
module serial_command_deframer import scd_pkg::*; #(
  parameter int unsigned BUFFER_BYTES   = 256,
  parameter int unsigned TEXT_MAX_CHARS = 14
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [7:0] data, [15:8] body_index, [18:16] status
  output logic        m_axis_tuser_o,   // [0] frame_kind
  output logic        m_axis_tlast_o
);

  logic  push;
  cmd_t  push_cmd;
  logic  q_room;
  logic  q_valid;
  cmd_t  q_head;
  logic  pop;
  item_t out_item;

  scd_parser #(
    .BUFFER_BYTES  (BUFFER_BYTES),
    .TEXT_MAX_CHARS(TEXT_MAX_CHARS)
  ) u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid_i),
    .in_ready_o(s_axis_tready_o),
    .rx_byte_i (s_axis_tdata_i),
    .q_room_i  (q_room),
    .push_o    (push),
    .cmd_o     (push_cmd)
  );

  scd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .pop_i  (pop),
    .valid_o(q_valid),
    .head_o (q_head),
    .room_o (q_room)
  );

  scd_emitter u_emitter (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_cmd_i    (q_head),
    .pop_o      (pop),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_item_o (out_item)
  );

  assign m_axis_tdata_o = {5'b0, out_item.status, out_item.index, out_item.data};
  assign m_axis_tuser_o = out_item.kind;
  assign m_axis_tlast_o = out_item.last;

endmodule
